### sv/aes_pkg.sv
// Shared types, constants and byte-level functions for the AES-128 core.
`timescale 1ns / 1ps

package aes_pkg;

   localparam int NumRounds = 10;
   localparam int RkDepth   = 2 * (NumRounds + 1);
   localparam int RoundW    = $clog2(NumRounds + 1);

   localparam logic [63:0] KeyHighReset = 64'h2b7e151628aed2a6;
   localparam logic [63:0] KeyLowReset  = 64'habf7158809cf4f3c;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   localparam logic KindEncrypt = 1'b0;
   localparam logic KindDecrypt = 1'b1;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_DONE
   } core_state_type;

   typedef enum logic [1:0] {
      KEX_IDLE,
      KEX_RUN
   } kex_state_type;

   // round request from the sequencer to the round unit
   typedef struct packed {
      logic decrypt;
      logic first;  // initial key addition only
      logic last;   // skip mix columns
   } round_ctl_type;

   localparam logic [7:0] SBox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] InvSBox [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] x);
      sub_word = {SBox[x[31:24]], SBox[x[23:16]], SBox[x[15:8]], SBox[x[7:0]]};
   endfunction

endpackage

### sv/aes_key_expand.sv
// Round key expansion: one round key per cycle into the round key memory.
`timescale 1ns / 1ps

module aes_key_expand
   import aes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [127:0]          key,
   input  logic [RoundW-1:0]     rd_round,
   output logic [127:0]          rd_key,
   output logic                  busy
);

   kex_state_type       state_ff, state_in;
   logic [RoundW-1:0]   round_ff, round_in;
   logic [127:0]        rk_ff, rk_in;
   logic [7:0]          rcon_ff, rcon_in;
   logic [127:0]        rk_mem [NumRounds + 1];
   logic                wr_en;
   logic [RoundW-1:0]   wr_addr;
   logic [127:0]        wr_data;
   logic [31:0]         t;
   logic [31:0]         w0, w1, w2, w3;

   // next round key from the previous one
   always_comb begin
      t  = sub_word({rk_ff[23:0], rk_ff[31:24]}) ^ {rcon_ff, 24'h0};
      w0 = rk_ff[127:96] ^ t;
      w1 = rk_ff[95:64] ^ w0;
      w2 = rk_ff[63:32] ^ w1;
      w3 = rk_ff[31:0] ^ w2;
   end

   // next state; a start while running begins again from the new key
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         KEX_IDLE: if (start) state_in = KEX_RUN;
         KEX_RUN:  if (!start && round_ff == RoundW'(NumRounds)) state_in = KEX_IDLE;
         default:  state_in = KEX_IDLE;
      endcase
   end

   // datapath and memory write
   always_comb begin
      round_in = round_ff;
      rk_in    = rk_ff;
      rcon_in  = rcon_ff;
      wr_en    = 1'b0;
      wr_addr  = round_ff;
      wr_data  = rk_ff;
      case (state_ff)
         KEX_IDLE: begin
            if (start) begin
               round_in = '0;
               rk_in    = key;
               rcon_in  = 8'h01;
            end
         end
         KEX_RUN: begin
            wr_en = 1'b1;
            if (start) begin
               round_in = '0;
               rk_in    = key;
               rcon_in  = 8'h01;
            end else begin
               round_in = round_ff + 1'b1;
               rk_in    = {w0, w1, w2, w3};
               rcon_in  = xtime(rcon_ff);
            end
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != KEX_IDLE) || start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KEX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      round_ff <= round_in;
      rk_ff    <= rk_in;
      rcon_ff  <= rcon_in;
   end

   // round key memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) rk_mem[wr_addr] <= wr_data;
      rd_key <= rk_mem[rd_round];
   end

endmodule

### sv/aes_round.sv
// One shared AES round, encrypt or decrypt, applied once per cycle.
`timescale 1ns / 1ps

module aes_round
   import aes_pkg::*;
(
   input  logic [127:0]  state_in,
   input  logic [127:0]  round_key,
   input  round_ctl_type ctl,
   output logic [127:0]  state_out
);

   logic [7:0] s [16];
   logic [7:0] sh [16];
   logic [7:0] sb [16];
   logic [7:0] ak [16];
   logic [7:0] mc [16];
   logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, x4, x5, x6, x7;

   always_comb begin
      for (int k = 0; k < 16; k++) s[k] = state_in[127 - 8*k -: 8];
      // shift rows (left for encrypt, right for decrypt)
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctl.decrypt) sh[c*4 + r] = s[((c + 3*r) % 4)*4 + r];
            else             sh[c*4 + r] = s[((c + r) % 4)*4 + r];
         end
      end
      for (int k = 0; k < 16; k++)
         sb[k] = ctl.decrypt ? InvSBox[sh[k]] : SBox[sh[k]];
      // encrypt adds the key after mixing, decrypt before
      for (int k = 0; k < 16; k++) ak[k] = sb[k] ^ round_key[127 - 8*k -: 8];
      for (int c = 0; c < 4; c++) begin
         a0 = ctl.decrypt ? ak[4*c]   : sb[4*c];
         a1 = ctl.decrypt ? ak[4*c+1] : sb[4*c+1];
         a2 = ctl.decrypt ? ak[4*c+2] : sb[4*c+2];
         a3 = ctl.decrypt ? ak[4*c+3] : sb[4*c+3];
         x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
         // double-doubled terms for the inverse matrix
         x4 = xtime(xtime(a0 ^ a2));
         x5 = xtime(xtime(a1 ^ a3));
         x6 = ctl.decrypt ? (a0 ^ x4) : a0;
         x7 = ctl.decrypt ? (a1 ^ x5) : a1;
         if (ctl.decrypt) begin
            // inverse mix = forward mix after pre-step
            a0 = x6; a1 = x7; a2 = a2 ^ x4; a3 = a3 ^ x5;
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
         end
         mc[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
         mc[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
         mc[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
         mc[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      end
      for (int k = 0; k < 16; k++) begin
         if (ctl.first)        state_out[127 - 8*k -: 8] = s[k] ^ round_key[127 - 8*k -: 8];
         else if (ctl.last)    state_out[127 - 8*k -: 8] = ak[k];
         else if (ctl.decrypt) state_out[127 - 8*k -: 8] = mc[k];
         else state_out[127 - 8*k -: 8] = mc[k] ^ round_key[127 - 8*k -: 8];
      end
   end

endmodule

### sv/aes128_block_cipher.sv
// Top level of the AES-128 block cipher: sequencer, key store and stream ports.
//
//   channel | ports    | direction | word
//   req     | req_t*   | in        | block plus encrypt/decrypt selector
//   rsp     | rsp_t*   | out       | transformed block
//   csr     | csr_*    | in        | key halves, written without handshake
//
// A block's result is ready after the initial key addition and ten rounds, one per cycle
// through the single round unit; the first round key is read at the accepting edge.
// The result is held in rsp_tdata until taken; req_tready returns the cycle after,
// so a new block is accepted only once the previous result has been taken.
// After reset and after each key write, expansion holds req_tready low until it ends;
// a key write during expansion starts it again.
`timescale 1ns / 1ps

module aes128_block_cipher
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_high, block_low
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_high, result_low
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   core_state_type    state_ff, state_in;
   logic [127:0]      blk_ff, blk_in;
   logic              dec_ff, dec_in;
   logic [RoundW-1:0] step_ff, step_in;
   logic [63:0]       key_hi_ff, key_lo_ff;
   logic              kex_start_ff;
   logic              kex_busy;
   logic [RoundW-1:0] rd_round;
   logic [127:0]      rd_key;
   logic [127:0]      round_out;
   round_ctl_type     ctl;
   logic              accept;

   // key registers; a write kicks off re-expansion
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= KeyHighReset;
         key_lo_ff    <= KeyLowReset;
         kex_start_ff <= 1'b1;
      end else begin
         kex_start_ff <= csr_we;
         if (csr_we && csr_addr == CsrKeyHigh) key_hi_ff <= csr_wdata;
         if (csr_we && csr_addr == CsrKeyLow)  key_lo_ff <= csr_wdata;
      end
   end

   aes_key_expand u_kex (
      .clock    (clock),
      .reset    (reset),
      .start    (kex_start_ff),
      .key      ({key_hi_ff, key_lo_ff}),
      .rd_round (rd_round),
      .rd_key   (rd_key),
      .busy     (kex_busy)
   );

   aes_round u_round (
      .state_in  (blk_ff),
      .round_key (rd_key),
      .ctl       (ctl),
      .state_out (round_out)
   );

   // internally byte 0 sits at the top of the block register
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == CORE_IDLE) && !kex_busy;
   assign rsp_tvalid = (state_ff == CORE_DONE);
   assign rsp_tdata  = {blk_ff[63:0], blk_ff[127:64]};

   // the accepting edge reads the key for the initial addition; steps 1..11 apply keys
   always_comb begin
      ctl.decrypt = dec_ff;
      ctl.first   = (step_ff == RoundW'(1));
      ctl.last    = (step_ff == RoundW'(NumRounds + 1));
   end

   // key address: one step ahead of the round that uses it
   always_comb begin
      logic [RoundW-1:0] r;
      r = accept ? '0 : step_ff;
      if (accept ? req_tuser : dec_ff) rd_round = RoundW'(NumRounds) - r;
      else                             rd_round = r;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORE_IDLE:  if (accept) state_in = CORE_ROUND;
         CORE_ROUND: if (step_ff == RoundW'(NumRounds + 1)) state_in = CORE_DONE;
         CORE_DONE:  if (rsp_tready) state_in = CORE_IDLE;
         default:    state_in = CORE_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      blk_in  = blk_ff;
      dec_in  = dec_ff;
      step_in = step_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (accept) begin
               blk_in  = {req_tdata[63:0], req_tdata[127:64]};
               dec_in  = req_tuser;
               step_in = RoundW'(1);
            end
         end
         CORE_ROUND: begin
            blk_in  = round_out;
            step_in = step_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      blk_ff  <= blk_in;
      dec_ff  <= dec_in;
      step_ff <= step_in;
   end

endmodule

### bench/aes128_checker.sv
// Block checker for the AES-128 cipher: predicts each result and compares it with the rsp word.
`timescale 1ns / 1ps

module aes128_checker
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // block_high, block_low
   input  logic         req_tuser,   // kind
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // result_high, result_low
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [63:0]  csr_wdata,
   output int           mismatches,
   output int           blocks_pending
);

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } cipher_block_type;

   logic [63:0]      key_hi_copy;
   logic [63:0]      key_lo_copy;
   logic [63:0]      sched [RkDepth];
   cipher_block_type blocks_due [$];

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   // key schedule: 44 words folded into 22 double words
   function automatic void build_schedule(input logic [63:0] khi, input logic [63:0] klo);
      logic [31:0] w [4 * (NumRounds + 1)];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      w[0] = khi[63:32];
      w[1] = khi[31:0];
      w[2] = klo[63:32];
      w[3] = klo[31:0];
      for (int i = 4; i < 4 * (NumRounds + 1); i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {SBox[t[23:16]], SBox[t[15:8]], SBox[t[7:0]], SBox[t[31:24]]} ^ {rc, 24'h0};
            rc = gf_double(rc);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r <= NumRounds; r++) begin
         sched[2 * r]     = {w[4 * r], w[4 * r + 1]};
         sched[2 * r + 1] = {w[4 * r + 2], w[4 * r + 3]};
      end
   endfunction

   // state byte k is byte k of the block, byte 0 in the top of the high half
   function automatic cipher_block_type transform_block(input logic decrypt,
                                                        input logic [63:0] bhi,
                                                        input logic [63:0] blo);
      logic [7:0]       s [16];
      logic [7:0]       t [16];
      logic [127:0]     rk;
      logic [7:0]       m [4];
      cipher_block_type res;
      int               rnd;
      for (int k = 0; k < 8; k++) begin
         s[k]     = bhi[63 - 8 * k -: 8];
         s[k + 8] = blo[63 - 8 * k -: 8];
      end
      if (decrypt) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else m = '{8'h02, 8'h03, 8'h01, 8'h01};
      rnd = decrypt ? NumRounds : 0;
      for (int step = 0; step <= NumRounds; step++) begin
         if (step > 0) begin
            // shift rows, left on the way in, right on the way back
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  t[c * 4 + r] = s[((c + (decrypt ? 3 : 1) * r) % 4) * 4 + r];
            for (int k = 0; k < 16; k++) s[k] = decrypt ? InvSBox[t[k]] : SBox[t[k]];
            // forward mix sits before the key, inverse mix after it
            if (!decrypt && step != NumRounds) begin
               t = s;
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++)
                     s[4 * c + r] = gf_mul(t[4 * c + r], m[0]) ^
                                    gf_mul(t[4 * c + (r + 1) % 4], m[1]) ^
                                    gf_mul(t[4 * c + (r + 2) % 4], m[2]) ^
                                    gf_mul(t[4 * c + (r + 3) % 4], m[3]);
            end
         end
         rk = {sched[2 * rnd], sched[2 * rnd + 1]};
         for (int k = 0; k < 16; k++) s[k] ^= rk[127 - 8 * k -: 8];
         if (decrypt && step > 0 && step != NumRounds) begin
            t = s;
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  s[4 * c + r] = gf_mul(t[4 * c + r], m[0]) ^
                                 gf_mul(t[4 * c + (r + 1) % 4], m[1]) ^
                                 gf_mul(t[4 * c + (r + 2) % 4], m[2]) ^
                                 gf_mul(t[4 * c + (r + 3) % 4], m[3]);
         end
         rnd = decrypt ? rnd - 1 : rnd + 1;
      end
      for (int k = 0; k < 8; k++) begin
         res.result_high[63 - 8 * k -: 8] = s[k];
         res.result_low[63 - 8 * k -: 8]  = s[k + 8];
      end
      return res;
   endfunction

   function automatic void report(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      if (mismatches < 10)
         $display("%0t rsp word %s: expected %h, got %h", $realtime, field, want, got);
      mismatches++;
   endfunction

   assign blocks_pending = blocks_due.size();

   initial begin
      mismatches  = 0;
      key_hi_copy = KeyHighReset;
      key_lo_copy = KeyLowReset;
      build_schedule(KeyHighReset, KeyLowReset);
   end

   always @(posedge clock) begin
      cipher_block_type want;
      if (reset) begin
         key_hi_copy = KeyHighReset;
         key_lo_copy = KeyLowReset;
         build_schedule(key_hi_copy, key_lo_copy);
         blocks_due.delete();
      end else begin
         // key writes must land only while the block is idle; the block itself does not enforce this
         if (csr_we) begin
            if (csr_addr == CsrKeyHigh) key_hi_copy = csr_wdata;
            else key_lo_copy = csr_wdata;
            build_schedule(key_hi_copy, key_lo_copy);
         end
         if (req_tvalid && req_tready)
            blocks_due.push_back(transform_block(req_tuser, req_tdata[63:0],
                                                 req_tdata[127:64]));
         if (rsp_tvalid && rsp_tready) begin
            if (blocks_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t rsp word %h with nothing outstanding", $realtime, rsp_tdata);
               mismatches++;
            end else begin
               want = blocks_due.pop_front();
               if (rsp_tdata[63:0] !== want.result_high)
                  report("result_high", want.result_high, rsp_tdata[63:0]);
               if (rsp_tdata[127:64] !== want.result_low)
                  report("result_low", want.result_low, rsp_tdata[127:64]);
            end
         end
      end
   end

endmodule

### bench/testbench.sv
// Top of the AES-128 cipher bench: clock, reset, stimulus, rsp back-pressure and verdict.
`timescale 1ns / 1ps

module testbench
   import aes_pkg::*;
();

   localparam int StallLimit = 3000;
   localparam int HoldCycles = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // block_high, block_low
   logic         req_tuser = 1'b0; // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // result_high, result_low
   logic         csr_we = 1'b0;
   logic [0:0]   csr_addr = CsrKeyHigh;
   logic [63:0]  csr_wdata = '0;

   int mismatches;
   int blocks_pending;
   int quiet_cycles = 0;
   int burst_left = 4;
   bit offering = 1'b0;
   bit hold_req = 1'b0;

   always #6 clock = ~clock;

   aes128_block_cipher u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata
   );

   aes128_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata,
      .mismatches, .blocks_pending
   );

   // offer one block word, then maybe pause between bursts
   task automatic send_block(input logic kind, input logic [63:0] bhi, input logic [63:0] blo);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {blo, bhi};
      req_tuser  <= kind;
      offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and let every outstanding result come back
   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
   endtask

   // write the selected key halves while the core is idle
   task automatic load_key(input bit do_hi, input logic [63:0] khi,
                           input bit do_lo, input logic [63:0] klo);
      drain();
      repeat (15) @(posedge clock);
      if (do_hi) begin
         csr_we    <= 1'b1;
         csr_addr  <= CsrKeyHigh;
         csr_wdata <= khi;
         @(posedge clock);
      end
      if (do_lo) begin
         csr_we    <= 1'b1;
         csr_addr  <= CsrKeyLow;
         csr_wdata <= klo;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] pick_half(input int mode);
      case (mode)
         0: return '0;
         1: return '1;
         2: return {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // rsp back-pressure: shifting stall pattern, plus one long hold-off on request
   initial begin
      int mode;
      bit held;
      held = 1'b0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("aes128_block_cipher regression: fail");
         $finish;
      end
   end

   initial begin
      logic [63:0] hi;
      logic [63:0] lo;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: standard vector under the reset key, extremes, both directions
      send_block(KindEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block(KindDecrypt, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
      send_block(KindEncrypt, '0, '0);
      send_block(KindDecrypt, '0, '0);
      send_block(KindEncrypt, '1, '1);
      send_block(KindDecrypt, '1, '1);
      send_block(KindEncrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(KindDecrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
      // a key write takes effect on the very next block
      load_key(1'b1, 64'h0001020304050607, 1'b1, 64'h08090a0b0c0d0e0f);
      send_block(KindEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(KindDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      load_key(1'b1, '0, 1'b1, '0);
      send_block(KindEncrypt, '0, '0);
      send_block(KindDecrypt, '1, '1);
      load_key(1'b1, '1, 1'b1, '1);
      send_block(KindEncrypt, '1, '0);
      send_block(KindDecrypt, '0, '1);
      load_key(1'b0, '0, 1'b1, 64'h8000000000000001);
      send_block(KindEncrypt, 64'h8000000000000000, 64'h0000000000000001);

      // random phases, each under a fresh key
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_key(1'b1, '0, 1'b0, '0);
            1: load_key(1'b1, '1, 1'b1, '0);
            2: load_key(1'b0, '0, 1'b1, '1);
            default: load_key(1'b1, {$urandom, $urandom}, ($urandom_range(0, 1) == 1),
                              {$urandom, $urandom});
         endcase
         for (int n = 0; n < 90; n++) begin
            if (phase == 3 && n == 20) hold_req = 1'b1;
            hi = pick_half($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
            lo = pick_half($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
            send_block(1'($urandom_range(0, 1)), hi, lo);
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("aes128_block_cipher regression: pass");
      end else begin
         $display("aes128_block_cipher regression: fail");
      end
      $finish;
   end

endmodule
